// File: rtl/core/sdss_pkg.sv
package sdss_pkg;

  // Field widths of the stream words.
  localparam int SPEED_W    = 12;
  localparam int DIST_W     = 16;
  localparam int ENABLE_W   = 6;
  localparam int SEG_W      = 7;
  localparam int POS_W      = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Widths of the precomputed quotients.
  localparam int SPEED_Q10_W  = 9;   // up to 409
  localparam int SPEED_Q100_W = 6;   // up to 40
  localparam int DIST_Q10_W   = 13;  // up to 6553
  localparam int DIST_Q100_W  = 10;  // up to 655

  // Scan positions.
  localparam logic [POS_W-1:0] POS_GEAR      = 3'd0;
  localparam logic [POS_W-1:0] POS_SPEED_H   = 3'd1;
  localparam logic [POS_W-1:0] POS_SPEED_T   = 3'd2;
  localparam logic [POS_W-1:0] POS_SPEED_U   = 3'd3;
  localparam logic [POS_W-1:0] POS_DIST_T    = 3'd4;
  localparam logic [POS_W-1:0] POS_DIST_U    = 3'd5;
  localparam logic [POS_W-1:0] POS_LAST      = POS_DIST_U;

  // Input word kinds.
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_BUTTON = 1'b1;

  // Segment patterns for the gear letters and a blank digit.
  localparam logic [SEG_W-1:0] SEG_LETTER_D = 7'd59;
  localparam logic [SEG_W-1:0] SEG_LETTER_R = 7'd100;
  localparam logic [SEG_W-1:0] SEG_BLANK    = 7'd0;

  // Quotients of the current word, computed on the way into the input register.
  typedef struct packed {
    logic [SPEED_W-1:0]      speed;
    logic [SPEED_Q10_W-1:0]  speed_q10;
    logic [SPEED_Q100_W-1:0] speed_q100;
    logic [DIST_W-1:0]       distance;
    logic [DIST_Q10_W-1:0]   dist_q10;
    logic [DIST_Q100_W-1:0]  dist_q100;
  } sdss_quot_t;

  // What the decoder hands back for one word.
  typedef struct packed {
    logic [ENABLE_W-1:0] enable;
    logic [SEG_W-1:0]    seg;
  } sdss_disp_t;

  // Decimal digit to segment pattern; anything above nine is blank.
  function automatic logic [SEG_W-1:0] digit_seg(input logic [5:0] v);
    logic [SEG_W-1:0] s;
    case (v)
      6'd0:    s = 7'd126;
      6'd1:    s = 7'd24;
      6'd2:    s = 7'd47;
      6'd3:    s = 7'd31;
      6'd4:    s = 7'd89;
      6'd5:    s = 7'd87;
      6'd6:    s = 7'd119;
      6'd7:    s = 7'd92;
      6'd8:    s = 7'd127;
      6'd9:    s = 7'd95;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/sdss_decode.sv
module sdss_decode (
  input  logic [sdss_pkg::POS_W-1:0] pos,
  input  logic                       gear_rev,
  input  sdss_pkg::sdss_quot_t       quot,
  output sdss_pkg::sdss_disp_t       disp
);
  import sdss_pkg::*;

  logic [SPEED_W-1:0]     speed_u_full;
  logic [SPEED_Q10_W-1:0] speed_t_full;
  logic [DIST_W-1:0]      dist_u_full;
  logic [DIST_Q10_W-1:0]  dist_t_full;

  // Remainders: value minus ten times its quotient, done with shifts and adds.
  assign speed_u_full = quot.speed
                      - (SPEED_W'(quot.speed_q10) << 3) - (SPEED_W'(quot.speed_q10) << 1);
  assign speed_t_full = quot.speed_q10
                      - (SPEED_Q10_W'(quot.speed_q100) << 3)
                      - (SPEED_Q10_W'(quot.speed_q100) << 1);
  assign dist_u_full  = quot.distance
                      - (DIST_W'(quot.dist_q10) << 3) - (DIST_W'(quot.dist_q10) << 1);
  assign dist_t_full  = quot.dist_q10
                      - (DIST_Q10_W'(quot.dist_q100) << 3)
                      - (DIST_Q10_W'(quot.dist_q100) << 1);

  // Pick the digit select and the symbol for the current scan position.
  always_comb begin
    case (pos)
      POS_GEAR: begin
        disp.enable = 6'b100000;
        disp.seg    = gear_rev ? SEG_LETTER_R : SEG_LETTER_D;
      end
      POS_SPEED_H: begin
        disp.enable = 6'b010000;
        disp.seg    = digit_seg(quot.speed_q100);
      end
      POS_SPEED_T: begin
        disp.enable = 6'b001000;
        disp.seg    = digit_seg({2'b00, speed_t_full[3:0]});
      end
      POS_SPEED_U: begin
        disp.enable = 6'b000100;
        disp.seg    = digit_seg({2'b00, speed_u_full[3:0]});
      end
      POS_DIST_T: begin
        disp.enable = 6'b000010;
        disp.seg    = digit_seg({2'b00, dist_t_full[3:0]});
      end
      POS_DIST_U: begin
        disp.enable = 6'b000001;
        disp.seg    = digit_seg({2'b00, dist_u_full[3:0]});
      end
      default: begin
        disp.enable = '0;
        disp.seg    = SEG_BLANK;
      end
    endcase
  end

endmodule

// File: rtl/core/six_digit_segment_scanner.sv
// Six-digit display scanner. Each input word is either a scan tick, which
// lights the next digit (gear letter, speed hundreds/tens/units, distance
// tens/units) and advances the scan position, or a gear button press, which
// toggles drive/reverse and returns a word with no digit lit. Every input word
// gives exactly one result word. A word is taken into the input register, where
// its divide-by-ten and divide-by-hundred quotients are already held, and is
// decoded into the result register once that one is empty or drained. One word
// is accepted every cycle while the output does not stall; the single decode
// stage between the two registers, which also updates the scan position and
// gear, sets that rate. The result register frees as soon as its word is taken.
module six_digit_segment_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] speed, [27:12] distance, [31:28] zero
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [5:0] digit_enable, [12:6] segments,
                                  // [13] reverse_gear, [15:14] zero
);
  import sdss_pkg::*;

  logic                  a_valid_r;
  logic                  a_func_r;
  sdss_quot_t            a_quot_r;
  sdss_quot_t            quot_nxt;
  logic                  a_advance;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  gear_r, gear_nxt;
  sdss_disp_t            disp;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [SPEED_W-1:0]    in_speed;
  logic [DIST_W-1:0]     in_dist;
  logic [28:0]           speed_p10;
  logic [24:0]           speed_p100;
  logic [32:0]           dist_p10;
  logic [32:0]           dist_p100;

  assign in_speed = in_tdata[SPEED_W-1:0];
  assign in_dist  = in_tdata[SPEED_W+DIST_W-1:SPEED_W];

  // Reciprocal multiplies for the quotients, exact over the full field ranges.
  assign speed_p10  = 29'(in_speed) * 29'd52429;
  assign speed_p100 = 25'(in_speed) * 25'd5243;
  assign dist_p10   = 33'(in_dist) * 33'd52429;
  assign dist_p100  = 33'(in_dist) * 33'd83887;

  always_comb begin
    quot_nxt.speed      = in_speed;
    quot_nxt.speed_q10  = speed_p10[27:19];
    quot_nxt.speed_q100 = speed_p100[24:19];
    quot_nxt.distance   = in_dist;
    quot_nxt.dist_q10   = dist_p10[31:19];
    quot_nxt.dist_q100  = dist_p100[32:23];
  end

  // The input stage moves on whenever the result register is empty or drained.
  assign a_advance = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_func_r <= in_tuser;
      a_quot_r <= quot_nxt;
    end
  end

  sdss_decode u_decode (
    .pos      (pos_r),
    .gear_rev (gear_r),
    .quot     (a_quot_r),
    .disp     (disp)
  );

  // Scan position and gear change only as a word leaves the input stage.
  always_comb begin
    pos_nxt      = pos_r;
    gear_nxt     = gear_r;
    out_data_nxt = '0;
    if (a_func_r == FUNC_BUTTON) begin
      gear_nxt = ~gear_r;
    end else begin
      pos_nxt = (pos_r >= POS_LAST) ? POS_GEAR : pos_r + 3'd1;
      out_data_nxt[ENABLE_W-1:0]            = disp.enable;
      out_data_nxt[ENABLE_W+SEG_W-1:ENABLE_W] = disp.seg;
    end
    out_data_nxt[ENABLE_W+SEG_W] = gear_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_GEAR;
      gear_r <= 1'b0;
    end else if (a_advance) begin
      pos_r  <= pos_nxt;
      gear_r <= gear_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // At most one digit is ever lit.
  a_onehot_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_data_r[ENABLE_W-1:0]))
    else $error("more than one digit enabled");

  // The scan position stays within the six digits.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("scan position out of range");

  // A button press flips the gear and leaves the scan position alone.
  a_button: assert property (@(posedge clk) disable iff (!rst_n)
    (a_advance && a_func_r == FUNC_BUTTON) |=> (gear_r != $past(gear_r)) && $stable(pos_r))
    else $error("button press handled wrongly");

  // The reported gear matches the gear state once the word is out.
  a_gear_out: assert property (@(posedge clk) disable iff (!rst_n)
    a_advance |=> out_data_r[ENABLE_W+SEG_W] == gear_r)
    else $error("reported gear differs from gear state");

endmodule

// File: bench/six_digit_segment_scanner_test.sv
module six_digit_segment_scanner_test;
  import sdss_pkg::*;

  // One word offered on the input stream, with the idle time placed before it.
  typedef struct {
    logic               func;
    logic [SPEED_W-1:0] speed;
    logic [DIST_W-1:0]  distance;
    int                 gap;
    bit                 drain_first;
  } scan_word_t;

  // One word of the result stream.
  typedef struct packed {
    logic [ENABLE_W-1:0] enable;
    logic [SEG_W-1:0]    seg;
    logic                reverse;
  } display_t;

  localparam int RANDOM_WORDS = 1030;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  scan_word_t pending_words[$];
  display_t   expected_display[$];

  // Scanner state as the predictor sees it.
  logic [POS_W-1:0] scan_pos = POS_GEAR;
  logic             gear_rev = 1'b0;

  int words_sent = 0;
  int words_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  six_digit_segment_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Segment pattern of one decimal digit; anything above nine is dark.
  function automatic logic [SEG_W-1:0] segment_of(input int v);
    case (v)
      0:       return 7'd126;
      1:       return 7'd24;
      2:       return 7'd47;
      3:       return 7'd31;
      4:       return 7'd89;
      5:       return 7'd87;
      6:       return 7'd119;
      7:       return 7'd92;
      8:       return 7'd127;
      9:       return 7'd95;
      default: return SEG_BLANK;
    endcase
  endfunction

  // Advance the predicted scanner by one word and return what it should show.
  function automatic display_t scan_step(input scan_word_t w);
    display_t d;
    int       spd;
    int       dst;
    spd = int'(w.speed);
    dst = int'(w.distance);
    d.enable = '0;
    d.seg = SEG_BLANK;
    if (w.func == FUNC_BUTTON) begin
      gear_rev = ~gear_rev;
    end else begin
      if (scan_pos <= POS_LAST) begin
        d.enable = ENABLE_W'(1) << (POS_LAST - scan_pos);
      end
      case (scan_pos)
        POS_GEAR:    d.seg = gear_rev ? SEG_LETTER_R : SEG_LETTER_D;
        POS_SPEED_H: d.seg = segment_of(spd / 100);
        POS_SPEED_T: d.seg = segment_of((spd / 10) % 10);
        POS_SPEED_U: d.seg = segment_of(spd % 10);
        POS_DIST_T:  d.seg = segment_of((dst / 10) % 10);
        POS_DIST_U:  d.seg = segment_of(dst % 10);
        default:     d.seg = SEG_BLANK;
      endcase
      scan_pos = (scan_pos >= POS_LAST) ? POS_GEAR : scan_pos + 1'b1;
    end
    d.reverse = gear_rev;
    return d;
  endfunction

  // Idle length before a word: mostly none, sometimes short, rarely long.
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Length of one receiver stall: mostly short, a few long ones.
  function automatic int stall_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  task automatic queue_word(input logic func, input int spd, input int dst,
                            input int gap, input bit drain_first);
    scan_word_t w;
    w.func = func;
    w.speed = spd[SPEED_W-1:0];
    w.distance = dst[DIST_W-1:0];
    w.gap = gap;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endtask

  // Driver: takes words from the pending queue and offers them on the input.
  scan_word_t cur_word;
  scan_word_t next_word;
  bit         have_next = 1'b0;
  bit         slot_busy;
  bit         took_now;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else begin
      took_now = in_tvalid && in_tready;
      slot_busy = in_tvalid && !in_tready;
      if (took_now) begin
        expected_display.push_back(scan_step(cur_word));
        words_sent <= words_sent + 1;
      end
      if (!slot_busy) begin
        if (!have_next && pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          gap_left = next_word.gap;
          have_next = 1'b1;
        end
        if (!have_next) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (next_word.drain_first &&
                     words_sent + int'(took_now) != words_seen) begin
          // Hold this word back until the scanner has emptied out.
          in_tvalid <= 1'b0;
        end else begin
          cur_word = next_word;
          have_next = 1'b0;
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W-DIST_W-SPEED_W){1'b0}}, next_word.distance,
                       next_word.speed};
          in_tuser <= next_word.func;
        end
      end
    end
  end

  // Monitor: checks each result word and throttles the output side.
  display_t got_display;
  display_t want_display;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       stall_left = 0;
  int       out_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_cycles = out_cycles + 1;
      if (out_tvalid && out_tready) begin
        got_display.enable = out_tdata[ENABLE_W-1:0];
        got_display.seg = out_tdata[ENABLE_W +: SEG_W];
        got_display.reverse = out_tdata[ENABLE_W+SEG_W];
        words_seen <= words_seen + 1;
        if (expected_display.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected result word 0x%h", $time, out_tdata);
        end else begin
          want_display = expected_display.pop_front();
          if (got_display.enable !== want_display.enable ||
              got_display.seg !== want_display.seg ||
              got_display.reverse !== want_display.reverse) begin
            mismatches = mismatches + 1;
            $display("%0t: expected enable=%b seg=%0d rev=%b, got enable=%b seg=%0d rev=%b",
                     $time, want_display.enable, want_display.seg, want_display.reverse,
                     got_display.enable, got_display.seg, got_display.reverse);
          end
        end
      end
      // One long hold-off once traffic is flowing, so the input side backs up.
      if (!hold_done && words_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if ((out_cycles / 150) % 3 != 0 && $urandom_range(0, 99) < 20) begin
        stall_left = stall_length() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int  i;
    int  gap;
    int  spd;
    bit  drain;
    // Full scan with every field at its maximum; the hundreds digit is forty.
    for (i = 0; i < 6; i++) queue_word(FUNC_TICK, 4095, 65535, 0, 1'b0);
    // Switch to reverse and scan all zeros.
    queue_word(FUNC_BUTTON, 0, 0, 0, 1'b0);
    for (i = 0; i < 6; i++) queue_word(FUNC_TICK, 0, 0, 0, 1'b0);
    // Button pressed in the middle of a scan leaves the position alone.
    queue_word(FUNC_TICK, 987, 12345, 0, 1'b0);
    queue_word(FUNC_TICK, 987, 12345, 1, 1'b0);
    queue_word(FUNC_BUTTON, 987, 12345, 0, 1'b0);
    for (i = 0; i < 4; i++) queue_word(FUNC_TICK, 987, 12346, 0, 1'b0);
    // Hundreds digit of exactly ten is dark too.
    queue_word(FUNC_TICK, 1000, 0, 0, 1'b0);
    queue_word(FUNC_TICK, 1000, 0, 0, 1'b0);

    // Random traffic with calm stretches and a gap-free run around the hold-off.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if ((i >= 360 && i < 560) || (i / 100) % 3 == 1) gap = 0;
      else gap = sender_gap();
      drain = (i == 0) || (i == 600) || ($urandom_range(0, 99) == 0);
      spd = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 4095);
      queue_word(($urandom_range(0, 99) < 12) ? FUNC_BUTTON : FUNC_TICK, spd,
                 $urandom_range(0, 65535), gap, drain);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Let everything drain, then give stray words a chance to show up.
    while (pending_words.size() != 0 || have_next || in_tvalid ||
           expected_display.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_display.size() == 0) begin
      $display("status: pass");
    end else begin
      if (expected_display.size() != 0) begin
        $display("%0t: %0d result words never arrived", $time, expected_display.size());
      end
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: six_digit_segment_scanner.f
rtl/core/sdss_pkg.sv
rtl/core/sdss_decode.sv
rtl/core/six_digit_segment_scanner.sv
bench/six_digit_segment_scanner_test.sv
